### sv/ubtr_pkg.sv
`default_nettype none

package ubtr_pkg;

	// default ring depth for both queues
	localparam int BUFFER_DEPTH_DEF = 16;

	// fixed payload widths
	localparam int BYTE_W  = 8;
	localparam int LEVEL_W = 5;

	// operation codes
	typedef enum logic [1:0] {
		OP_HOST_WRITE = 2'd0,
		OP_HOST_READ  = 2'd1,
		OP_TX_DONE    = 2'd2,
		OP_RX_BYTE    = 2'd3
	} op_t;

endpackage

`default_nettype wire

### sv/ubtr_ram.sv
`default_nettype none

module ubtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/uart_buffered_tx_rx_engine.sv
`default_nettype none

// UART byte buffer: a transmit and a receive ring queue of BUFFER_DEPTH bytes (a power of
// two, 2 to 16), each held in a single-port-write RAM with a registered read, plus a
// transmitter busy flag. Each request carries one operation (host write, host read,
// transmit done, byte received) and yields exactly one response. The queue pointers and
// fill counts update at acceptance and the RAM is read in the same cycle, its registered
// data lands in the output register on the next edge. A new request is taken once no
// request waits in stage one for RAM data and the output register is empty or being
// drained, so a new request cannot be taken while the last one is still in flight.
// When a host write starts an idle transmitter on an empty queue, the byte is forwarded
// straight to send_byte rather than being read back from the RAM.
module uart_buffered_tx_rx_engine #(
	parameter int BUFFER_DEPTH = ubtr_pkg::BUFFER_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     opcode,
	input  wire logic [ubtr_pkg::BYTE_W-1:0]    data_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                status,
	output logic      [ubtr_pkg::BYTE_W-1:0]    rx_data,
	output logic                                send_valid,
	output logic      [ubtr_pkg::BYTE_W-1:0]    send_byte,
	output logic      [ubtr_pkg::LEVEL_W-1:0]   rx_level,
	output logic                                tx_active
);

	localparam int IW = $clog2(BUFFER_DEPTH);
	localparam int FW = IW + 1;
	localparam logic [FW-1:0] FULL = FW'(BUFFER_DEPTH);

	// queue state
	logic [IW-1:0] tx_head_q, rx_head_q;
	logic [FW-1:0] tx_fill_q, rx_fill_q;
	logic          busy_q;

	logic [IW-1:0] tx_head_d, rx_head_d;
	logic [FW-1:0] tx_fill_d, rx_fill_d;
	logic          busy_d;

	// ram controls
	logic                        tx_we, rx_we, tx_re, rx_re;
	logic [IW-1:0]               tx_waddr, rx_waddr, tx_raddr, rx_raddr;
	logic [ubtr_pkg::BYTE_W-1:0] tx_rdata, rx_rdata;

	// response fields decided at acceptance
	logic                        res_status, res_send, res_fwd, res_rd_rx;
	logic [FW-1:0]               fill_a;
	logic [IW-1:0]               head_a;

	// stage one: waiting for ram data
	logic                        s1_valid;
	logic                        status_s1, send_s1, fwd_s1, rd_rx_s1, active_s1;
	logic [ubtr_pkg::BYTE_W-1:0] fwd_byte_s1;
	logic [FW-1:0]               level_s1;

	// output register
	logic                        out_valid_q, status_q, send_q, active_q;
	logic [ubtr_pkg::BYTE_W-1:0] rx_data_q, send_byte_q;
	logic [ubtr_pkg::LEVEL_W-1:0] level_q;

	logic accept;

	// take a request when nothing is in flight and the output is free or draining
	assign in_stall = s1_valid | (out_valid_q & out_stall);
	assign accept   = in_valid & ~in_stall;

	// operation decode and pointer arithmetic
	always_comb begin
		tx_head_d  = tx_head_q;
		rx_head_d  = rx_head_q;
		tx_fill_d  = tx_fill_q;
		rx_fill_d  = rx_fill_q;
		busy_d     = busy_q;
		tx_we      = 1'b0;
		rx_we      = 1'b0;
		tx_re      = 1'b0;
		rx_re      = 1'b0;
		tx_waddr   = tx_head_q;
		rx_waddr   = rx_head_q;
		tx_raddr   = tx_head_q - tx_fill_q[IW-1:0];
		rx_raddr   = rx_head_q - rx_fill_q[IW-1:0];
		res_status = 1'b0;
		res_send   = 1'b0;
		res_fwd    = 1'b0;
		res_rd_rx  = 1'b0;
		fill_a     = tx_fill_q;
		head_a     = tx_head_q;
		unique case (ubtr_pkg::op_t'(opcode))
			ubtr_pkg::OP_HOST_WRITE: begin
				// queue the byte, then start the shifter if idle
				if (tx_fill_q == FULL) begin
					res_status = 1'b1;
				end else begin
					tx_we  = accept;
					head_a = tx_head_q + IW'(1);
					fill_a = tx_fill_q + FW'(1);
				end
				tx_head_d = head_a;
				tx_fill_d = fill_a;
				if (!busy_q) begin
					if (fill_a == '0) begin
						busy_d = 1'b0;
					end else begin
						busy_d    = 1'b1;
						res_send  = 1'b1;
						res_fwd   = (tx_fill_q == '0);
						tx_re     = accept & (tx_fill_q != '0);
						tx_raddr  = head_a - fill_a[IW-1:0];
						tx_fill_d = fill_a - FW'(1);
					end
				end
			end
			ubtr_pkg::OP_HOST_READ: begin
				// pop a received byte
				if (rx_fill_q == '0) begin
					res_status = 1'b1;
				end else begin
					res_rd_rx = 1'b1;
					rx_re     = accept;
					rx_fill_d = rx_fill_q - FW'(1);
				end
			end
			ubtr_pkg::OP_TX_DONE: begin
				// hand on the next byte or go idle
				if (tx_fill_q == '0) begin
					busy_d = 1'b0;
				end else begin
					res_send  = 1'b1;
					tx_re     = accept;
					tx_fill_d = tx_fill_q - FW'(1);
				end
			end
			ubtr_pkg::OP_RX_BYTE: begin
				// queue a received byte or drop it
				if (rx_fill_q == FULL) begin
					res_status = 1'b1;
				end else begin
					rx_we     = accept;
					rx_head_d = rx_head_q + IW'(1);
					rx_fill_d = rx_fill_q + FW'(1);
				end
			end
			default: begin
				res_status = 1'b0;
			end
		endcase
	end

	// queue state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q <= '0;
			rx_head_q <= '0;
			tx_fill_q <= '0;
			rx_fill_q <= '0;
			busy_q    <= 1'b0;
		end else if (accept) begin
			tx_head_q <= tx_head_d;
			rx_head_q <= rx_head_d;
			tx_fill_q <= tx_fill_d;
			rx_fill_q <= rx_fill_d;
			busy_q    <= busy_d;
		end
	end

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= accept;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1   <= res_status;
			send_s1     <= res_send;
			fwd_s1      <= res_fwd;
			rd_rx_s1    <= res_rd_rx;
			active_s1   <= busy_d;
			fwd_byte_s1 <= data_in;
			level_s1    <= rx_fill_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload, merging ram data
	always_ff @(posedge clk) begin
		if (s1_valid) begin
			status_q    <= status_s1;
			send_q      <= send_s1;
			active_q    <= active_s1;
			level_q     <= ubtr_pkg::LEVEL_W'(level_s1);
			rx_data_q   <= rd_rx_s1 ? rx_rdata : '0;
			send_byte_q <= !send_s1 ? '0 : (fwd_s1 ? fwd_byte_s1 : tx_rdata);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign rx_data    = rx_data_q;
	assign send_valid = send_q;
	assign send_byte  = send_byte_q;
	assign rx_level   = level_q;
	assign tx_active  = active_q;

	// transmit queue storage
	ubtr_ram #(
		.WIDTH(ubtr_pkg::BYTE_W),
		.DEPTH(BUFFER_DEPTH)
	) u_tx_ram (
		.clk  (clk),
		.we   (tx_we),
		.waddr(tx_waddr),
		.wdata(data_in),
		.re   (tx_re),
		.raddr(tx_raddr),
		.rdata(tx_rdata)
	);

	// receive queue storage
	ubtr_ram #(
		.WIDTH(ubtr_pkg::BYTE_W),
		.DEPTH(BUFFER_DEPTH)
	) u_rx_ram (
		.clk  (clk),
		.we   (rx_we),
		.waddr(rx_waddr),
		.wdata(data_in),
		.re   (rx_re),
		.raddr(rx_raddr),
		.rdata(rx_rdata)
	);

endmodule

`default_nettype wire
